// ----- rtl/core/gsd_pkg.sv -----
package gsd_pkg;

   localparam int DATA_WIDTH     = 12;
   localparam int CHECK_WIDTH    = 11;
   localparam int REM_WIDTH      = DATA_WIDTH + CHECK_WIDTH;
   localparam int WORD_BITS      = 24;
   localparam int FLIP_WIDTH     = 5;
   localparam int SUM_GROWTH     = 5;
   localparam int SOFT_WIDTH_DEF = 8;

   localparam logic [DATA_WIDTH-1:0] POLY_RESET = 12'd3189;
   localparam logic [DATA_WIDTH-1:0] DATA_MASK  = 12'hFFF;

   // one candidate codeword in flight along the cell row
   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] data;
      logic [REM_WIDTH-1:0]  rem;
      logic                  parity;
      logic [FLIP_WIDTH-1:0] flips;
   } cand_type;

endpackage

// ----- rtl/core/gsd_req_if.sv -----
interface gsd_req_if
   import gsd_pkg::*;
#(
   parameter int SOFT_WIDTH = SOFT_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [SOFT_WIDTH-1:0] soft_value;

   modport source (output valid, output soft_value, input ready);
   modport sink   (input valid, input soft_value, output ready);
endinterface

// ----- rtl/core/gsd_rsp_if.sv -----
interface gsd_rsp_if
   import gsd_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] decoded_data;
   logic [FLIP_WIDTH-1:0] flip_count;

   modport source (output valid, output decoded_data, output flip_count, input ready);
   modport sink   (input valid, input decoded_data, input flip_count, output ready);
endinterface

// ----- rtl/core/gsd_cell.sv -----
module gsd_cell
   import gsd_pkg::*;
#(
   parameter int SOFT_WIDTH = SOFT_WIDTH_DEF,
   parameter int POS        = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load_en,
   input  logic signed [SOFT_WIDTH-1:0]          soft_in,
   output logic signed [SOFT_WIDTH-1:0]          soft_out,
   input  logic [DATA_WIDTH-1:0]                 poly,
   input  cand_type                              cand_in,
   input  logic signed [SOFT_WIDTH+SUM_GROWTH-1:0] sum_in,
   output cand_type                              cand_out,
   output logic signed [SOFT_WIDTH+SUM_GROWTH-1:0] sum_out
);

   localparam int SUM_WIDTH = SOFT_WIDTH + SUM_GROWTH;

   logic signed [SOFT_WIDTH-1:0] soft_ff;
   logic                         code_bit;
   logic                         hard_bit;
   logic [REM_WIDTH-1:0]         rem_in;
   cand_type                     cand_nxt_in;
   cand_type                     cand_ff;
   logic signed [SUM_WIDTH-1:0]  sum_nxt_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         soft_ff <= soft_in;
      end
   end

   assign soft_out = soft_ff;
   assign hard_bit = soft_ff[SOFT_WIDTH-1];

   generate
      if (POS < DATA_WIDTH) begin : g_data
         localparam int SHIFT = CHECK_WIDTH - POS;
         logic [REM_WIDTH-1:0] poly_shift;
         assign poly_shift = {{(REM_WIDTH-DATA_WIDTH){1'b0}}, poly} << SHIFT;
         assign code_bit   = cand_in.data[DATA_WIDTH-1-POS];
         // one long-division step at this bit position
         assign rem_in     = cand_in.rem[REM_WIDTH-1-POS] ? (cand_in.rem ^ poly_shift)
                                                          : cand_in.rem;
      end else if (POS < WORD_BITS - 1) begin : g_check
         assign code_bit = cand_in.rem[REM_WIDTH-1-POS];
         assign rem_in   = cand_in.rem;
      end else begin : g_parity
         assign code_bit = cand_in.parity;
         assign rem_in   = cand_in.rem;
      end
   endgenerate

   always_comb begin
      cand_nxt_in        = cand_in;
      cand_nxt_in.rem    = rem_in;
      cand_nxt_in.parity = cand_in.parity ^ code_bit;
      cand_nxt_in.flips  = cand_in.flips + FLIP_WIDTH'(code_bit ^ hard_bit);
      sum_nxt_in         = code_bit ? (sum_in + SUM_WIDTH'(soft_ff)) : sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff.valid <= cand_nxt_in.valid;
      end
      cand_ff.data   <= cand_nxt_in.data;
      cand_ff.rem    <= cand_nxt_in.rem;
      cand_ff.parity <= cand_nxt_in.parity;
      cand_ff.flips  <= cand_nxt_in.flips;
      sum_ff         <= sum_nxt_in;
   end

   assign cand_out = cand_ff;
   assign sum_out  = sum_ff;

endmodule

// ----- rtl/core/gsd_select.sv -----
module gsd_select
   import gsd_pkg::*;
#(
   parameter int SOFT_WIDTH = SOFT_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cand_type                                tail,
   input  logic signed [SOFT_WIDTH+SUM_GROWTH-1:0] tail_sum,
   output logic                                    pending,
   gsd_rsp_if.source                               rsp_chan
);

   localparam int SUM_WIDTH = SOFT_WIDTH + SUM_GROWTH;

   logic signed [SUM_WIDTH-1:0] best_sum_ff;
   logic [DATA_WIDTH-1:0]       best_data_ff;
   logic [FLIP_WIDTH-1:0]       best_flips_ff;
   logic                        pending_ff;
   logic                        pending_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [DATA_WIDTH-1:0]       rsp_data_ff;
   logic [FLIP_WIDTH-1:0]       rsp_flips_ff;
   logic                        take;
   logic                        commit;

   // strict compare: on a tie the earlier (lower) data value stays
   assign take   = tail.valid && ((tail.data == '0) || (tail_sum < best_sum_ff));
   assign commit = pending_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (take) begin
         best_sum_ff   <= tail_sum;
         best_data_ff  <= tail.data;
         best_flips_ff <= tail.flips;
      end
      if (commit) begin
         rsp_data_ff  <= best_data_ff;
         rsp_flips_ff <= best_flips_ff;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      if (commit) begin
         pending_in = 1'b0;
      end
      if (tail.valid && (tail.data == DATA_MASK)) begin
         pending_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign pending               = pending_ff;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.decoded_data = rsp_data_ff;
   assign rsp_chan.flip_count   = rsp_flips_ff;

endmodule

// ----- rtl/core/golay_24_12_soft_decoder.sv -----
// Soft-decision ML decoder for the extended (24,12) Golay code.
// req_chan carries one signed soft value per transfer, first code bit first;
// positive leans to 0. Every 24 values form one codeword; the 24th
// starts a search over all 4096 codewords. rsp_chan then carries the
// decoded 12 data bits and the count of bits that differ from the hard
// decisions. csr_write_en/csr_write_data load the generator polynomial.
// Values 1 to 23 of a word are taken one per cycle. The search feeds one
// candidate per cycle into a row of 24 cells, each holding one soft value;
// the row adds up the metric as the candidate walks through it. The
// selector keeps the lowest sum; once the last candidate has left the
// row, the best result moves into the output register when that is free
// and rsp_chan.valid rises. Reset clears the word position, empties the
// row and drops any result; the polynomial returns to 0xC75. While a
// result waits on a stalled receiver the next word is still loaded;
// its search starts once the waiting result is in the output register.
module golay_24_12_soft_decoder
   import gsd_pkg::*;
#(
   parameter int SOFT_WIDTH = SOFT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gsd_req_if.sink               req_chan,
   gsd_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [DATA_WIDTH-1:0] csr_write_data
);

   localparam int SUM_WIDTH = SOFT_WIDTH + SUM_GROWTH;
   localparam int CNT_WIDTH = $clog2(WORD_BITS);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_START  = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic [CNT_WIDTH-1:0]        value_cnt_ff;
   logic [CNT_WIDTH-1:0]        value_cnt_in;
   logic [DATA_WIDTH-1:0]       cand_ctr_ff;
   logic [DATA_WIDTH-1:0]       cand_ctr_in;
   logic [DATA_WIDTH-1:0]       poly_ff;
   logic                        accept;
   logic                        sel_pending;
   logic                        tail_last;

   cand_type                    chain [0:WORD_BITS];
   logic signed [SUM_WIDTH-1:0] sums  [0:WORD_BITS];
   logic signed [SOFT_WIDTH-1:0] soft_link [0:WORD_BITS-1];

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign accept         = req_chan.valid && req_chan.ready;
   assign tail_last      = chain[WORD_BITS].valid && (chain[WORD_BITS].data == DATA_MASK);

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else if (csr_write_en) begin
         poly_ff <= csr_write_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      value_cnt_in = value_cnt_ff;
      cand_ctr_in  = cand_ctr_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (value_cnt_ff == CNT_WIDTH'(WORD_BITS - 1)) begin
                  value_cnt_in = '0;
                  state_in     = ST_START;
               end else begin
                  value_cnt_in = value_cnt_ff + CNT_WIDTH'(1);
               end
            end
         end
         ST_START: begin
            if (!sel_pending) begin
               cand_ctr_in = '0;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cand_ctr_in = cand_ctr_ff + DATA_WIDTH'(1);
            if (cand_ctr_ff == DATA_MASK) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tail_last) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         value_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         value_cnt_ff <= value_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ctr_ff <= cand_ctr_in;
   end

   assign chain[0] = '{valid:  (state_ff == ST_SEARCH),
                       data:   cand_ctr_ff,
                       rem:    {cand_ctr_ff, {CHECK_WIDTH{1'b0}}},
                       parity: 1'b0,
                       flips:  '0};
   assign sums[0]  = '0;

   generate
      for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
         logic signed [SOFT_WIDTH-1:0] soft_in;
         if (i == WORD_BITS - 1) begin : g_head
            assign soft_in = req_chan.soft_value;
         end else begin : g_link
            assign soft_in = soft_link[i+1];
         end
         gsd_cell #(
            .SOFT_WIDTH (SOFT_WIDTH),
            .POS        (i)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .load_en  (accept),
            .soft_in  (soft_in),
            .soft_out (soft_link[i]),
            .poly     (poly_ff),
            .cand_in  (chain[i]),
            .sum_in   (sums[i]),
            .cand_out (chain[i+1]),
            .sum_out  (sums[i+1])
         );
      end
   endgenerate

   gsd_select #(
      .SOFT_WIDTH (SOFT_WIDTH)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .tail     (chain[WORD_BITS]),
      .tail_sum (sums[WORD_BITS]),
      .pending  (sel_pending),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   a_search_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> !sel_pending)
      else $error("search running while a result is pending");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && cand_ctr_ff == DATA_MASK) |=> (state_ff == ST_DRAIN))
      else $error("search did not stop after the last candidate");

   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      chain[WORD_BITS].valid |-> (state_ff == ST_SEARCH || state_ff == ST_DRAIN))
      else $error("candidate left the row outside a search");

   a_value_cnt_range: assert property (@(posedge clock) disable iff (reset)
      value_cnt_ff < CNT_WIDTH'(WORD_BITS))
      else $error("word position out of range");

   a_rsp_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(sel_pending))
      else $error("result shown without a finished search");
`endif

endmodule
